[rtl/mfbp_pkg.sv]
// ---------------------------------------------------------------------------
// mfbp_pkg
// shared types and constants of the msb-first bit packer
// ---------------------------------------------------------------------------
package mfbp_pkg;

   localparam int OPCODE_W = 3;
   localparam int VALUE_W  = 24;
   localparam int LENGTH_W = 5;
   localparam int BUF_W    = 32;
   localparam int SUM_W    = 6;   // pending count plus one code length
   localparam int BYTE_W   = 8;
   localparam int TOTAL_W  = 32;

   // input opcodes
   localparam logic [OPCODE_W-1:0] OP_START        = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_WRITE        = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_MASKED_WRITE = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_FINISH       = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_FINISH_MARK  = 3'd4;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_WRITE,
      CMD_FINISH,
      CMD_FINISH_MARK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [VALUE_W-1:0]    value;
      logic [LENGTH_W-1:0]   length;
   } cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0]     out_byte;
      logic                  byte_valid;
      logic                  done_res;
      logic                  is_last;
      logic [TOTAL_W-1:0]    byte_total;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_FLUSH,
      ST_REPORT
   } back_state_type;

   // handshake between the back end and the queues around it
   typedef struct packed {
      logic cmd_pop;
      logic rsp_push;
   } back_ctrl_type;

endpackage

[rtl/mfbp_fifo.sv]
// ---------------------------------------------------------------------------
// mfbp_fifo
// small first-in first-out queue with full and empty flags
// ---------------------------------------------------------------------------
module mfbp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = AW + 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/mfbp_front.sv]
// ---------------------------------------------------------------------------
// mfbp_front
// decodes an input item into a packer command and drops unknown opcodes
// ---------------------------------------------------------------------------
module mfbp_front
   import mfbp_pkg::*;
#(
   parameter int MAX_CODE_LENGTH = 24
) (
   input  logic [OPCODE_W-1:0] opcode,
   input  logic [VALUE_W-1:0]  code_value,
   input  logic [LENGTH_W-1:0] code_length,
   output logic                cmd_valid,
   output cmd_type             cmd
);

   localparam logic [LENGTH_W-1:0] MAX_LEN = LENGTH_W'(MAX_CODE_LENGTH);

   logic [LENGTH_W-1:0] len_sat;
   logic [VALUE_W+1:0]  mask_wide;

   assign len_sat   = (code_length > MAX_LEN) ? MAX_LEN : code_length;
   // lengths of the full value width or more keep every bit
   assign mask_wide = ((VALUE_W + 2)'(1) << len_sat) - (VALUE_W + 2)'(1);

   always_comb begin
      cmd_valid  = 1'b1;
      cmd.kind   = CMD_START;
      cmd.value  = code_value;
      cmd.length = len_sat;
      unique case (opcode)
         OP_START:        cmd.kind = CMD_START;
         OP_WRITE:        cmd.kind = CMD_WRITE;
         OP_MASKED_WRITE: begin
            cmd.kind  = CMD_WRITE;
            cmd.value = code_value & mask_wide[VALUE_W-1:0];
         end
         OP_FINISH:       cmd.kind = CMD_FINISH;
         OP_FINISH_MARK:  cmd.kind = CMD_FINISH_MARK;
         default:         cmd_valid = 1'b0;
      endcase
   end

endmodule

[rtl/mfbp_back.sv]
// ---------------------------------------------------------------------------
// mfbp_back
// bit buffer, pending count and byte counter; turns commands into items
// ---------------------------------------------------------------------------
module mfbp_back
   import mfbp_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  logic          cmd_empty,
   input  logic          rsp_full,
   output back_ctrl_type ctrl,
   output rsp_item_type  rsp_item
);

   back_state_type         state_ff, state_in;
   logic [BUF_W-1:0]       buf_ff, buf_in;
   logic [SUM_W-1:0]       pend_ff, pend_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   fin_ff, fin_in;

   logic [SUM_W-1:0]               sum;
   logic [SUM_W-1:0]               rem;
   logic [COUNT_WIDTH+TOTAL_W-1:0] count_ext;

   assign rem       = pend_ff - SUM_W'(BYTE_W);
   assign count_ext = {{TOTAL_W{1'b0}}, count_ff};

   always_comb begin
      state_in = state_ff;
      buf_in   = buf_ff;
      pend_in  = pend_ff;
      count_in = count_ff;
      fin_in   = fin_ff;
      ctrl     = '0;
      rsp_item = '0;
      sum      = pend_ff + SUM_W'(cmd.length);
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               ctrl.cmd_pop = 1'b1;
               unique case (cmd.kind)
                  CMD_START: begin
                     buf_in   = '0;
                     pend_in  = '0;
                     count_in = '0;
                  end
                  CMD_WRITE: begin
                     buf_in   = (buf_ff << cmd.length) | BUF_W'(cmd.value);
                     pend_in  = sum;
                     fin_in   = 1'b0;
                     state_in = (sum >= SUM_W'(BYTE_W)) ? ST_EMIT : ST_IDLE;
                  end
                  CMD_FINISH: begin
                     state_in = ST_FLUSH;
                  end
                  CMD_FINISH_MARK: begin
                     // end sentinel: a single 1 bit
                     sum      = pend_ff + SUM_W'(1);
                     buf_in   = (buf_ff << 1) | BUF_W'(1);
                     pend_in  = sum;
                     fin_in   = 1'b1;
                     state_in = (sum >= SUM_W'(BYTE_W)) ? ST_EMIT : ST_FLUSH;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_EMIT: begin
            if (!rsp_full) begin
               ctrl.rsp_push       = 1'b1;
               rsp_item.out_byte   = BYTE_W'(buf_ff >> rem);
               rsp_item.byte_valid = 1'b1;
               rsp_item.is_last    = (rem < SUM_W'(BYTE_W)) && !fin_ff;
               count_in            = count_ff + 1'b1;
               pend_in             = rem;
               if (rem < SUM_W'(BYTE_W)) begin
                  state_in = fin_ff ? ST_FLUSH : ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (!rsp_full) begin
               ctrl.rsp_push = 1'b1;
               if (pend_ff != '0) begin
                  // leftover bits, zero padded at the bottom
                  rsp_item.out_byte   = BYTE_W'(buf_ff << (SUM_W'(BYTE_W) - pend_ff));
                  rsp_item.byte_valid = 1'b1;
                  count_in            = count_ff + 1'b1;
                  state_in            = ST_REPORT;
               end else begin
                  rsp_item.done_res   = 1'b1;
                  rsp_item.is_last    = 1'b1;
                  rsp_item.byte_total = count_ext[TOTAL_W-1:0];
                  state_in            = ST_IDLE;
               end
            end
         end
         ST_REPORT: begin
            if (!rsp_full) begin
               ctrl.rsp_push       = 1'b1;
               rsp_item.done_res   = 1'b1;
               rsp_item.is_last    = 1'b1;
               rsp_item.byte_total = count_ext[TOTAL_W-1:0];
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         buf_ff   <= '0;
         pend_ff  <= '0;
         count_ff <= '0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         buf_ff   <= buf_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

[rtl/msb_first_bit_packer.sv]
// ---------------------------------------------------------------------------
// msb_first_bit_packer
// Packs variable-length codes, most significant bit first, into bytes. Push
// items on the req_ side while full is low; opcodes are start, write, masked
// write, finish and finish with a 1-bit end sentinel, and unknown opcodes are
// taken and dropped. Each emitted byte comes out as one rsp_ item, and a
// finish ends with a report item carrying the byte count since start; the
// final item of each input has is_last set. The front decodes in the accept
// cycle into a two-entry command queue. The back end takes a command in its
// idle state and then writes one result item per cycle, while the two-entry
// result queue has room, so a write runs the emit state once per released
// byte and a finish runs the flush state and, when bits are pending, the
// report state; it takes no new command until the last one is done.
// ---------------------------------------------------------------------------
module msb_first_bit_packer
   import mfbp_pkg::*;
#(
   parameter int MAX_CODE_LENGTH = 24,
   parameter int COUNT_WIDTH     = 32
) (
   input  logic                clock,
   input  logic                reset,
   // input item queue side
   input  logic                req_push,
   output logic                req_full,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [VALUE_W-1:0]  req_code_value,
   input  logic [LENGTH_W-1:0] req_code_length,
   // result item queue side
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_done_res,
   output logic                rsp_is_last,
   output logic [TOTAL_W-1:0]  rsp_byte_total
);

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   // front to command queue
   logic          dec_valid;
   cmd_type       dec_cmd;
   logic          cmd_push;
   logic          cmd_full;
   logic          cmd_empty;
   cmd_type       cmd_head;

   // back end to result queue
   back_ctrl_type back_ctrl;
   rsp_item_type  back_item;
   logic          rsp_full;
   rsp_item_type  rsp_head;

   // decode and classify the incoming item
   mfbp_front #(
      .MAX_CODE_LENGTH(MAX_CODE_LENGTH)
   ) u_front (
      .opcode     (req_opcode),
      .code_value (req_code_value),
      .code_length(req_code_length),
      .cmd_valid  (dec_valid),
      .cmd        (dec_cmd)
   );

   // an item is taken whenever the command queue has room, unknown ones vanish
   assign req_full = cmd_full;
   assign cmd_push = req_push && !cmd_full && dec_valid;

   // command queue, lets the front keep accepting while the back end works
   mfbp_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (cmd_push),
      .wr_data(dec_cmd),
      .pop    (back_ctrl.cmd_pop),
      .rd_data(cmd_head),
      .full   (cmd_full),
      .empty  (cmd_empty)
   );

   // bit buffer and byte sequencer
   mfbp_back #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd_head),
      .cmd_empty(cmd_empty),
      .rsp_full (rsp_full),
      .ctrl     (back_ctrl),
      .rsp_item (back_item)
   );

   // result queue, the head item drives the rsp_ ports
   mfbp_fifo #(
      .WIDTH($bits(rsp_item_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (back_ctrl.rsp_push),
      .wr_data(back_item),
      .pop    (rsp_pop),
      .rd_data(rsp_head),
      .full   (rsp_full),
      .empty  (rsp_empty)
   );

   assign rsp_out_byte   = rsp_head.out_byte;
   assign rsp_byte_valid = rsp_head.byte_valid;
   assign rsp_done_res   = rsp_head.done_res;
   assign rsp_is_last    = rsp_head.is_last;
   assign rsp_byte_total = rsp_head.byte_total;

   // back end never writes a result into a full queue
   a_no_rsp_overrun: assert property (@(posedge clock) disable iff (reset)
      back_ctrl.rsp_push |-> !rsp_full)
      else $error("result written while result queue full");

   // back end never pops an empty command queue
   a_no_cmd_underrun: assert property (@(posedge clock) disable iff (reset)
      back_ctrl.cmd_pop |-> !cmd_empty)
      else $error("command popped from empty queue");

   // a report item carries no byte and always closes its input
   a_report_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_done_res) |-> (!rsp_byte_valid && rsp_is_last))
      else $error("malformed finish report item");

   // nothing waits on the result side right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

endmodule

[dv/tb_msb_first_bit_packer.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_msb_first_bit_packer
// Drives code items into the packer through its req_ queue side and pops
// packed bytes and finish reports from the rsp_ side. A small scoreboard
// packs the same codes in its own bit buffer and checks every popped item,
// field by field, against the oldest packed byte or report it expects.
// ---------------------------------------------------------------------------
module tb_msb_first_bit_packer
   import mfbp_pkg::*;
;

   localparam int          MAX_LEN      = 24;
   localparam int          COUNT_W      = 32;
   localparam int unsigned STALL_CYCLES = 150;   // long receiver hold-off
   localparam int unsigned TAIL_CYCLES  = 30;    // quiet time after the last item
   localparam int unsigned WATCHDOG_MAX = 4000;  // cycles with no item moving on either side
   localparam int unsigned RANDOM_ITEMS = 100;

   // ------------------------------------------------------------------------
   // expected packed stream: own bit buffer, pending count and byte count
   // ------------------------------------------------------------------------
   class packed_stream_scoreboard;
      bit [BUF_W-1:0]   bits_held;
      int unsigned      bits_pending;
      bit [TOTAL_W-1:0] byte_count;
      rsp_item_type     awaited_items[$];
      int unsigned      mismatches;

      function new();
         clear_stream();
         mismatches = 0;
      endfunction

      function void clear_stream();
         bits_held    = '0;
         bits_pending = 0;
         byte_count   = '0;
      endfunction

      function int unsigned outstanding();
         return awaited_items.size();
      endfunction

      function void emit_byte(bit [BYTE_W-1:0] b);
         rsp_item_type item;
         item            = '0;
         item.out_byte   = b;
         item.byte_valid = 1'b1;
         awaited_items.push_back(item);
         byte_count++;
      endfunction

      // shift a code in msb first, release every whole byte
      function void append_code(bit [BUF_W-1:0] v, int unsigned len);
         bits_held    = (bits_held << len) | v;
         bits_pending += len;
         while (bits_pending >= 8) begin
            bits_pending -= 8;
            emit_byte(BYTE_W'(bits_held >> bits_pending));
         end
      endfunction

      // leftover bits go out zero padded; buffer and count stay as they are
      function void flush_and_report();
         rsp_item_type item;
         if (bits_pending != 0 && bits_pending < 8)
            emit_byte(BYTE_W'(bits_held << (8 - bits_pending)));
         item            = '0;
         item.done_res   = 1'b1;
         item.byte_total = byte_count;
         awaited_items.push_back(item);
      endfunction

      function void note_code(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] value,
                              logic [LENGTH_W-1:0] length);
         int unsigned    len;
         int unsigned    before_size;
         bit [BUF_W-1:0] v;
         rsp_item_type   tail;
         before_size = awaited_items.size();
         len = (length > MAX_LEN) ? MAX_LEN : length;
         v   = BUF_W'(value);
         case (op)
            OP_START: clear_stream();
            OP_WRITE: append_code(v, len);
            OP_MASKED_WRITE: begin
               v = v & ((BUF_W'(1) << len) - 1);
               append_code(v, len);
            end
            OP_FINISH: flush_and_report();
            OP_FINISH_MARK: begin
               append_code(BUF_W'(1), 1);
               flush_and_report();
            end
            default: ;
         endcase
         if (awaited_items.size() > before_size) begin
            tail = awaited_items.pop_back();
            tail.is_last = 1'b1;
            awaited_items.push_back(tail);
         end
      endfunction

      function void check_item(rsp_item_type got);
         rsp_item_type want;
         if (awaited_items.size() == 0) begin
            $error("unexpected result item: out_byte %0h done_res %0b",
                   got.out_byte, got.done_res);
            mismatches++;
            return;
         end
         want = awaited_items.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
            mismatches++;
         end
         if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, actual %0b", want.byte_valid, got.byte_valid);
            mismatches++;
         end
         if (got.done_res !== want.done_res) begin
            $error("done_res: expected %0b, actual %0b", want.done_res, got.done_res);
            mismatches++;
         end
         if (got.is_last !== want.is_last) begin
            $error("is_last: expected %0b, actual %0b", want.is_last, got.is_last);
            mismatches++;
         end
         if (got.byte_total !== want.byte_total) begin
            $error("byte_total: expected %0d, actual %0d", want.byte_total, got.byte_total);
            mismatches++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // clock, reset and block inputs, all known from time zero
   // ------------------------------------------------------------------------
   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_push        = 1'b0;
   logic                req_full;
   logic [OPCODE_W-1:0] req_opcode      = '0;
   logic [VALUE_W-1:0]  req_code_value  = '0;
   logic [LENGTH_W-1:0] req_code_length = '0;
   logic                rsp_empty;
   logic                rsp_pop         = 1'b0;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_byte_valid;
   logic                rsp_done_res;
   logic                rsp_is_last;
   logic [TOTAL_W-1:0]  rsp_byte_total;

   packed_stream_scoreboard sb;

   // handshake between the two sides of the testbench
   bit          stall_ask = 1'b0;   // sender asks the receiver for one long hold-off
   bit          calm      = 1'b0;   // neither side takes random gaps while set
   int unsigned codes_sent;         // items that the block acts on

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   msb_first_bit_packer #(
      .MAX_CODE_LENGTH (MAX_LEN),
      .COUNT_WIDTH     (COUNT_W)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_code_value  (req_code_value),
      .req_code_length (req_code_length),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_done_res    (rsp_done_res),
      .rsp_is_last     (rsp_is_last),
      .rsp_byte_total  (rsp_byte_total)
   );

   // ------------------------------------------------------------------------
   // sender helpers
   // ------------------------------------------------------------------------

   // mostly back to back or short gaps, now and then a long one
   function automatic int unsigned sender_gap();
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // offer one item until the queue takes it; called at a rising edge.
   // with gap 0 push stays high so the next item follows without a bubble
   task automatic push_item(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] value,
                            logic [LENGTH_W-1:0] length, int unsigned gap);
      req_push        <= 1'b1;
      req_opcode      <= op;
      req_code_value  <= value;
      req_code_length <= length;
      @(posedge clock);
      while (req_full) @(posedge clock);
      // taken at this edge
      sb.note_code(op, value, length);
      if (op <= OP_FINISH_MARK) codes_sent++;
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop push so a stale item is not offered again while the sender waits
   task automatic go_quiet();
      req_push <= 1'b0;
   endtask

   task automatic push_random_code();
      logic [OPCODE_W-1:0] op;
      logic [LENGTH_W-1:0] len;
      int unsigned         r;
      r  = $urandom_range(0, 99);
      op = (r < 75) ? OP_MASKED_WRITE : OP_WRITE;
      r  = $urandom_range(0, 99);
      if (r < 85)      len = LENGTH_W'($urandom_range(1, MAX_LEN));
      else if (r < 92) len = '0;
      else             len = LENGTH_W'($urandom_range(MAX_LEN + 1, 31));
      push_item(op, VALUE_W'($urandom), len, sender_gap());
   endtask

   // finish or finish with sentinel, sometimes finished twice
   task automatic push_random_finish();
      logic [OPCODE_W-1:0] op;
      op = ($urandom_range(0, 1) != 0) ? OP_FINISH_MARK : OP_FINISH;
      push_item(op, VALUE_W'($urandom), LENGTH_W'($urandom), sender_gap());
      if ($urandom_range(0, 9) == 0)
         push_item(OP_FINISH, VALUE_W'($urandom), LENGTH_W'($urandom), sender_gap());
   endtask

   // well-formed stream: start, a few codes, a finish
   task automatic push_frame(int unsigned n_codes);
      push_item(OP_START, VALUE_W'($urandom), LENGTH_W'($urandom), sender_gap());
      repeat (n_codes) push_random_code();
      push_random_finish();
   endtask

   // ------------------------------------------------------------------------
   // sender: reset, directed items, pressure, random streams, end
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned frame_idx;
      int unsigned r;
      sb = new();
      codes_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every opcode, the corner cases
      push_item(OP_START,        24'h000000, 5'd0,  sender_gap());
      push_item(OP_WRITE,        24'hFFFFFF, 5'd24, sender_gap()); // three full bytes
      push_item(OP_MASKED_WRITE, 24'hFFFFFF, 5'd0,  sender_gap()); // masked to nothing
      push_item(OP_WRITE,        24'h000003, 5'd0,  sender_gap()); // zero length still ors in
      push_item(OP_MASKED_WRITE, 24'hABCDEF, 5'd31, sender_gap()); // length saturates
      push_item(OP_WRITE,        24'h000005, 5'd3,  sender_gap()); // leaves bits pending
      push_item(OP_FINISH,       24'h000000, 5'd0,  sender_gap());
      push_item(OP_FINISH,       24'hFFFFFF, 5'd31, sender_gap()); // same leftover again
      push_item(OP_FINISH_MARK,  24'h000000, 5'd0,  sender_gap());
      push_item(3'd5,            24'hFFFFFF, 5'd31, sender_gap()); // unknown opcodes
      push_item(3'd6,            24'h5A5A5A, 5'd8,  sender_gap());
      push_item(3'd7,            24'hA5A5A5, 5'd16, sender_gap());
      push_item(OP_START,        24'hFFFFFF, 5'd31, sender_gap());
      push_item(OP_FINISH,       24'h000000, 5'd0,  sender_gap()); // empty stream
      push_item(OP_FINISH_MARK,  24'h000000, 5'd0,  sender_gap()); // sentinel alone
      push_item(OP_START,        24'h000000, 5'd0,  sender_gap());
      push_item(OP_MASKED_WRITE, 24'h000000, 5'd24, sender_gap());
      push_item(OP_WRITE,        24'h800001, 5'd1,  sender_gap()); // junk above length
      push_item(OP_MASKED_WRITE, 24'h00005A, 5'd7,  sender_gap());
      push_item(OP_MASKED_WRITE, 24'hFFFFFF, 5'd16, sender_gap());
      push_item(OP_WRITE,        24'h0F0F0F, 5'd24, sender_gap());
      push_item(OP_FINISH_MARK,  24'hFFFFFF, 5'd31, sender_gap());

      // pressure: receiver holds off while the sender pushes back to back
      stall_ask = 1'b1;
      calm      = 1'b1;
      repeat (3) push_frame(6);
      calm = 1'b0;
      go_quiet();
      // sender pauses until the block has drained
      while (sb.outstanding() != 0) @(posedge clock);

      // random part: mostly well-formed streams, some noise and broken ones
      codes_sent = 0;
      frame_idx  = 0;
      while (codes_sent < RANDOM_ITEMS) begin
         calm = (frame_idx % 8 == 5);
         r = $urandom_range(0, 99);
         if (r < 10)
            push_item(OPCODE_W'($urandom_range(5, 7)), VALUE_W'($urandom),
                      LENGTH_W'($urandom), sender_gap());
         else if (r < 18) begin
            // codes and a finish with no start in front
            repeat ($urandom_range(1, 4)) push_random_code();
            push_random_finish();
         end else
            push_frame($urandom_range(1, 10));
         frame_idx++;
      end
      calm = 1'b0;
      go_quiet();

      // wait for everything expected, then a little longer for strays
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------------
   // receiver: pops at random, one long hold-off when the sender asks
   // ------------------------------------------------------------------------
   initial begin : result_side
      int unsigned  idle_left;
      int unsigned  hold_left;
      int unsigned  r;
      bit           stall_done;
      rsp_item_type got;
      idle_left  = 0;
      hold_left  = 0;
      stall_done = 1'b0;
      forever begin
         @(posedge clock);
         // values seen here are the ones the block saw at this edge
         if (!reset && rsp_pop && !rsp_empty) begin
            got.out_byte   = rsp_out_byte;
            got.byte_valid = rsp_byte_valid;
            got.done_res   = rsp_done_res;
            got.is_last    = rsp_is_last;
            got.byte_total = rsp_byte_total;
            sb.check_item(got);
         end
         if (stall_ask && !stall_done) begin
            hold_left  = STALL_CYCLES;
            stall_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (idle_left != 0 && !calm) begin
            idle_left--;
            rsp_pop <= 1'b0;
         end else begin
            idle_left = 0;
            rsp_pop <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 15)      idle_left = $urandom_range(1, 3);
            else if (r < 17) idle_left = $urandom_range(15, 40);
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: too long with no item moving on either side
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

endmodule
